FILE: hdl/ant_pkg.sv
// ----------------------------------------------------------------------------
// ant_pkg
// Shared constants, codes and types of the active note tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package ant_pkg;

    // default sizes
    localparam int PORTS_DEF      = 8;
    localparam int CHANNELS_DEF   = 16;
    localparam int NOTE_SLOTS_DEF = 16384;
    localparam int COUNT_BITS_DEF = 16;

    // field widths
    localparam int FUNC_W    = 2;
    localparam int PORT_W    = 3;
    localparam int CH_W      = 4;
    localparam int IDX_W     = 20;
    localparam int NCOUNT_W  = 15;
    localparam int TOTAL_W   = 24;
    localparam int MASK_W    = 16;
    localparam int EV_W      = 2;

    localparam int IN_DATA_W  = 32;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 72;
    localparam int OUT_USER_W = 3;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    // operations
    localparam logic [FUNC_W-1:0] FUNC_ACTIVATE   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DEACTIVATE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RESET      = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_QUERY      = 2'd3;

    // forwarded event kinds
    localparam logic [EV_W-1:0] EV_NONE       = 2'd0;
    localparam logic [EV_W-1:0] EV_ACTIVATE   = 2'd1;
    localparam logic [EV_W-1:0] EV_DEACTIVATE = 2'd2;
    localparam logic [EV_W-1:0] EV_RESET      = 2'd3;

    // register index, taken from paddr[2]
    localparam logic REG_NOTE_COUNT = 1'b0;

    // request to the flag store
    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic             wr_data;
        logic             clear;
    } flag_req_t;

endpackage

`default_nettype wire

FILE: hdl/ant_flag_mem.sv
// ----------------------------------------------------------------------------
// ant_flag_mem
// Note activation flags: one-bit synchronous RAM with a clearing sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module ant_flag_mem #(
    parameter int NOTE_SLOTS = ant_pkg::NOTE_SLOTS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ant_pkg::flag_req_t req,
    output logic                   rd_data,
    output logic                   busy
);

    localparam int AW = (NOTE_SLOTS > 1) ? $clog2(NOTE_SLOTS) : 1;
    localparam logic [AW-1:0] LAST = AW'(NOTE_SLOTS - 1);

    logic mem [NOTE_SLOTS];

    logic          sweep_reg, sweep_next;
    logic [AW-1:0] sweep_cnt_reg, sweep_cnt_next;
    logic          rd_data_reg;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          wr_data;

    always_comb
    begin
        sweep_next     = sweep_reg;
        sweep_cnt_next = sweep_cnt_reg;
        if (req.clear)
        begin
            sweep_next     = 1'b1;
            sweep_cnt_next = '0;
        end
        else if (sweep_reg)
        begin
            if (sweep_cnt_reg == LAST)
                sweep_next = 1'b0;
            else
                sweep_cnt_next = sweep_cnt_reg + 1'b1;
        end
    end

    // item writes win over the sweep write of that cycle
    always_comb
    begin
        if (req.wr_en)
        begin
            wr_en   = 1'b1;
            wr_addr = req.wr_addr[AW-1:0];
            wr_data = req.wr_data;
        end
        else
        begin
            wr_en   = sweep_reg;
            wr_addr = sweep_cnt_reg;
            wr_data = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg     <= 1'b1;
            sweep_cnt_reg <= '0;
        end
        else
        begin
            sweep_reg     <= sweep_next;
            sweep_cnt_reg <= sweep_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (req.rd_en)
            rd_data_reg <= mem[req.rd_addr[AW-1:0]];
    end

    assign rd_data = rd_data_reg;
    assign busy    = sweep_reg;

endmodule

`default_nettype wire

FILE: hdl/active_note_tracker.sv
// Path: an accepted word is held in input registers while the counter and flag RAMs are
//   read; its result is then registered in the output register, which waits while the sink holds the last one.
// Flow: no new word is accepted until the previous one has been written back to the
//   channel counter RAM and the flag RAM and passed to the output register.
// Reset: counters, total and peak clear at once; the flag RAM is then swept clear of
//   all NOTE_SLOTS entries with no word accepted, as after a reset word or a note_count write.
// ----------------------------------------------------------------------------
// active_note_tracker
// Counts sounding notes per port and channel, with activation flags per note.
// ----------------------------------------------------------------------------
`default_nettype none

module active_note_tracker #(
    parameter int PORTS      = ant_pkg::PORTS_DEF,
    parameter int CHANNELS   = ant_pkg::CHANNELS_DEF,
    parameter int NOTE_SLOTS = ant_pkg::NOTE_SLOTS_DEF,
    parameter int COUNT_BITS = ant_pkg::COUNT_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // input stream
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // [1:0] func, [4:2] port_no, [8:5] ch_no, [28:9] note_index
    input  wire logic [ant_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // [0] is_lyric
    input  wire logic [ant_pkg::IN_USER_W-1:0]  s_axis_tuser,
    // output stream
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // [0] count_changed, [16:1] port_channel_mask, [17] port_active,
    // [18] channel_active, [42:19] total_active, [66:43] peak_active
    output logic [ant_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // [1:0] listener_event, [2] event_is_lyric
    output logic [ant_pkg::OUT_USER_W-1:0]      m_axis_tuser,
    // configuration
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [ant_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [ant_pkg::PDATA_W-1:0]    pwdata,
    output logic [ant_pkg::PDATA_W-1:0]         prdata,
    output logic                                pready
);

    localparam int ENTRIES = PORTS * CHANNELS;
    localparam int CAW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;

    // ------------------------------------------------------------------ config
    logic [ant_pkg::NCOUNT_W-1:0] note_count_reg;
    logic                         cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == ant_pkg::REG_NOTE_COUNT);
    assign prdata = (paddr[2] == ant_pkg::REG_NOTE_COUNT)
                  ? {{(ant_pkg::PDATA_W - ant_pkg::NCOUNT_W){1'b0}}, note_count_reg}
                  : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            note_count_reg <= '0;
        else if (cfg_wr)
            note_count_reg <= pwdata[ant_pkg::NCOUNT_W-1:0];
    end

    // --------------------------------------------------------------- input side
    logic [1:0] state_reg, state_next;
    logic       flag_busy;
    logic       s_accept;
    logic       exec_go;

    logic [ant_pkg::PORT_W-1:0] in_port;
    logic [ant_pkg::CH_W-1:0]   in_ch;
    logic [CAW-1:0]             in_addr;

    assign in_port  = s_axis_tdata[4:2];
    assign in_ch    = s_axis_tdata[8:5];
    assign in_addr  = CAW'(int'(in_port) * CHANNELS + int'(in_ch));

    assign s_axis_tready = (state_reg == ST_IDLE) && !flag_busy;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    // held word
    logic [ant_pkg::FUNC_W-1:0] func_reg;
    logic                       lyric_reg;
    logic [ant_pkg::PORT_W-1:0] port_reg;
    logic [ant_pkg::CH_W-1:0]   ch_reg;
    logic [ant_pkg::IDX_W-1:0]  idx_reg;
    logic [CAW-1:0]             addr_reg;

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            func_reg  <= s_axis_tdata[1:0];
            lyric_reg <= s_axis_tuser[0];
            port_reg  <= in_port;
            ch_reg    <= in_ch;
            idx_reg   <= s_axis_tdata[28:9];
            addr_reg  <= in_addr;
        end
    end

    // ---------------------------------------------------------- counter RAM
    logic [COUNT_BITS-1:0] cnt_mem [ENTRIES];
    logic [COUNT_BITS-1:0] cnt_q;
    logic                  cnt_we;
    logic [COUNT_BITS-1:0] cnt_new;

    always_ff @(posedge clk)
    begin
        if (cnt_we)
            cnt_mem[addr_reg] <= cnt_new;
        if (s_accept)
            cnt_q <= cnt_mem[in_addr];
    end

    // nonzero bit per counter; a clear bit means the RAM entry reads as zero
    logic [ENTRIES-1:0] nz_reg, nz_next;
    logic [ant_pkg::TOTAL_W-1:0] total_reg, total_next;
    logic [ant_pkg::TOTAL_W-1:0] peak_reg, peak_next;

    // ---------------------------------------------------------- flag store
    ant_pkg::flag_req_t flag_req;
    logic               flag_rd;
    logic               flag_we;
    logic               flag_wd;

    ant_flag_mem #(
        .NOTE_SLOTS (NOTE_SLOTS)
    ) u_flags (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (flag_req),
        .rd_data (flag_rd),
        .busy    (flag_busy)
    );

    // ---------------------------------------------------------- update
    logic                        out_valid_reg;
    logic                        port_ok, inrange;
    logic [COUNT_BITS-1:0]       cur;
    logic                        idx_ok;
    logic                        dec;
    logic                        changed;
    logic [ant_pkg::EV_W-1:0]    ev;
    logic                        evl;
    logic                        is_reset;
    logic [ant_pkg::MASK_W-1:0]  mask;
    logic                        ch_act;

    assign exec_go = (state_reg == ST_EXEC) && (!out_valid_reg || m_axis_tready);

    assign port_ok = {2'b00, port_reg} < 5'(PORTS);
    assign inrange = port_ok && ({1'b0, ch_reg} < 5'(CHANNELS));
    assign cur     = (inrange && nz_reg[addr_reg]) ? cnt_q : '0;
    assign idx_ok  = (idx_reg < {5'b0, note_count_reg})
                  && ({1'b0, idx_reg} < 21'(NOTE_SLOTS));
    assign is_reset = (func_reg == ant_pkg::FUNC_RESET);

    always_comb
    begin
        nz_next    = nz_reg;
        total_next = total_reg;
        peak_next  = peak_reg;
        cnt_new    = cur;
        cnt_we     = 1'b0;
        flag_we    = 1'b0;
        flag_wd    = 1'b0;
        changed    = 1'b0;
        dec        = 1'b0;
        ev         = ant_pkg::EV_NONE;
        evl        = 1'b0;
        case (func_reg)
            ant_pkg::FUNC_ACTIVATE:
            begin
                ev  = ant_pkg::EV_ACTIVATE;
                evl = lyric_reg;
                if (!lyric_reg && inrange)
                begin
                    flag_we = idx_ok;
                    flag_wd = 1'b1;
                    if (cur != CNT_MAX)
                    begin
                        cnt_new = cur + 1'b1;
                        cnt_we  = 1'b1;
                        changed = 1'b1;
                    end
                    if (total_reg != ant_pkg::TOTAL_MAX)
                    begin
                        total_next = total_reg + 1'b1;
                        changed    = 1'b1;
                    end
                    if (total_next > peak_reg)
                        peak_next = total_next;
                end
            end
            ant_pkg::FUNC_DEACTIVATE:
            begin
                ev  = ant_pkg::EV_DEACTIVATE;
                evl = lyric_reg;
                if (!lyric_reg && inrange)
                begin
                    // note_count of zero turns off flag checking
                    if (note_count_reg == '0)
                        dec = (cur != '0);
                    else
                    begin
                        dec     = idx_ok && flag_rd;
                        flag_we = dec;
                        flag_wd = 1'b0;
                    end
                    if (dec)
                    begin
                        if (cur != '0)
                        begin
                            cnt_new = cur - 1'b1;
                            cnt_we  = 1'b1;
                            changed = 1'b1;
                        end
                        if (total_reg != '0)
                        begin
                            total_next = total_reg - 1'b1;
                            changed    = 1'b1;
                        end
                    end
                end
            end
            ant_pkg::FUNC_RESET:
            begin
                ev         = ant_pkg::EV_RESET;
                nz_next    = '0;
                total_next = '0;
                peak_next  = '0;
                changed    = 1'b1;
            end
            default:
            begin
                ev = ant_pkg::EV_NONE;
            end
        endcase
        if (cnt_we)
            nz_next[addr_reg] = (cnt_new != '0);
        cnt_we = cnt_we && exec_go;
    end

    // mask of the port after the update
    always_comb
    begin
        mask = '0;
        for (int c = 0; c < CHANNELS; c++)
        begin
            if (port_ok)
                mask[c] = nz_next[CAW'(int'(port_reg) * CHANNELS + c)];
        end
        ch_act = inrange && nz_next[addr_reg];
    end

    always_comb
    begin
        flag_req.rd_en   = s_accept;
        flag_req.rd_addr = s_axis_tdata[28:9];
        flag_req.wr_en   = exec_go && flag_we;
        flag_req.wr_addr = idx_reg;
        flag_req.wr_data = flag_wd;
        flag_req.clear   = (exec_go && is_reset) || cfg_wr;
    end

    // ---------------------------------------------------------- control
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (s_accept)
                    state_next = ST_EXEC;
            ST_EXEC:
                if (exec_go)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            nz_reg    <= '0;
            total_reg <= '0;
            peak_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (exec_go)
            begin
                nz_reg    <= nz_next;
                total_reg <= total_next;
                peak_reg  <= peak_next;
            end
        end
    end

    // ---------------------------------------------------------- output register
    logic [ant_pkg::OUT_DATA_W-1:0] out_data_reg;
    logic [ant_pkg::OUT_USER_W-1:0] out_user_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (exec_go)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (exec_go)
        begin
            out_data_reg <= {5'b0, peak_next, total_next, ch_act, (mask != '0),
                             mask, changed};
            out_user_reg <= {evl, ev};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule

`default_nettype wire

FILE: hdl/ant_checker.sv
// ----------------------------------------------------------------------------
// ant_checker
// Port-level checks of the active note tracker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ant_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           s_axis_tvalid,
    input wire logic                           s_axis_tready,
    input wire logic [ant_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input wire logic [ant_pkg::IN_USER_W-1:0]  s_axis_tuser,
    input wire logic                           m_axis_tvalid,
    input wire logic                           m_axis_tready,
    input wire logic [ant_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input wire logic [ant_pkg::OUT_USER_W-1:0] m_axis_tuser,
    input wire logic                           psel,
    input wire logic                           penable,
    input wire logic                           pwrite,
    input wire logic [ant_pkg::PADDR_W-1:0]    paddr,
    input wire logic [ant_pkg::PDATA_W-1:0]    pwdata,
    input wire logic [ant_pkg::PDATA_W-1:0]    prdata,
    input wire logic                           pready
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                            && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    a_peak_ge_total: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[66:43] >= m_axis_tdata[42:19])
        else $error("peak below total");

    a_port_active: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[17] == (m_axis_tdata[16:1] != 16'd0))
        else $error("port_active disagrees with mask");

    a_reset_result: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser[1:0] == ant_pkg::EV_RESET)
        |-> m_axis_tdata[0] && (m_axis_tdata[66:1] == 66'd0) && !m_axis_tuser[2])
        else $error("reset result not cleared");

    a_query_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser[1:0] == ant_pkg::EV_NONE)
        |-> !m_axis_tdata[0] && !m_axis_tuser[2])
        else $error("query result reports a change");

endmodule

bind active_note_tracker ant_checker u_ant_checker (.*);

`default_nettype wire
